// ===== rtl/core/multitap_keypad_text_entry_assert.svh =====
// Assertion macros used by the core RTL.
`ifndef MULTITAP_KEYPAD_TEXT_ENTRY_ASSERT_SVH
`define MULTITAP_KEYPAD_TEXT_ENTRY_ASSERT_SVH

// Check cons in the same cycle as ante.
`define MKTE_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define MKTE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mkte_pkg.sv =====
package mkte_pkg;

   localparam int BUF_DEPTH = 128;
   localparam int ADDR_W    = $clog2(BUF_DEPTH);
   localparam int CUR_W     = ADDR_W + 1;
   localparam int CHAR_W    = 7;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_KEY   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [3:0] KEY_SPACE  = 4'd0;
   localparam logic [3:0] KEY_DELETE = 4'd9;
   localparam logic [3:0] KEY_NONE   = 4'd15;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;

   localparam logic [7:0] TIMEOUT_RESET = 8'd5;
   localparam logic [7:0] IDLE_MAX      = 8'd255;

   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic signed [CUR_W-1:0] cursor_type;

   localparam addr_type   ADDR_LAST = addr_type'(BUF_DEPTH - 1);
   localparam cursor_type CUR_TOP   = cursor_type'(BUF_DEPTH - 1);
   localparam cursor_type CUR_NEG   = cursor_type'(-1);

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_KEY
   } state_type;

   function automatic logic [4:0] group_start(input logic [3:0] key);
      logic [4:0] s;
      unique case (key)
         4'd2:    s = 5'd3;
         4'd3:    s = 5'd6;
         4'd4:    s = 5'd9;
         4'd5:    s = 5'd12;
         4'd6:    s = 5'd15;
         4'd7:    s = 5'd19;
         4'd8:    s = 5'd22;
         4'd9:    s = 5'd26;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   function automatic logic [2:0] group_size(input logic [3:0] key);
      logic [2:0] s;
      unique case (key)
         4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd7: s = 3'd3;
         4'd6, 4'd8:                         s = 3'd4;
         default:                            s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic cursor_type cur_advance(input cursor_type c);
      cursor_type r;
      if (c == CUR_TOP) begin
         r = CUR_TOP;
      end else begin
         r = cursor_type'(c + cursor_type'(1));
      end
      return r;
   endfunction

   function automatic addr_type cur_slot(input cursor_type c);
      addr_type r;
      if (c[CUR_W-1]) begin
         r = '0;
      end else begin
         r = c[ADDR_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/mkte_if.sv =====
interface mkte_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [3:0] key;

   modport source(output valid, operation, key, input ready);
   modport sink(input valid, operation, key, output ready);
endinterface

interface mkte_rsp_if;
   logic       valid;
   logic       ready;
   logic       wrote;
   logic [6:0] write_index;
   logic [6:0] write_char;
   logic [7:0] cursor_now;

   modport source(output valid, wrote, write_index, write_char, cursor_now, input ready);
   modport sink(input valid, wrote, write_index, write_char, cursor_now, output ready);
endinterface

interface mkte_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

// ===== rtl/core/mkte_ram.sv =====
module mkte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/multitap_keypad_text_entry.sv =====
// Multi-tap keypad text entry into a character buffer.
// req carries one transaction per operation (tick, key press, clear); rsp returns
// exactly one transaction per request: whether a character was written, where,
// which character, and the cursor afterwards. csr writes the repeat timeout
// (idle ticks) and is always ready; write it only while the block is idle.
// Tick, clear and ignored requests answer in the cycle after acceptance. A key
// press passes through ST_KEY: the buffer slot under the cursor is read from the
// single-port-read RAM, then, once the output register is free, the new character
// is written back, so a new key is not taken until the last one is written back.
// Clear, and reset, sweep the buffer with spaces one entry per cycle over all BUF_DEPTH
// entries (128), during which req is not ready; rsp for a clear is sent at once.
// rsp sits in an output register: when the receiver stalls, one finished
// transaction waits there, a new request is still taken if the register frees
// in the same cycle, and otherwise req holds off.
// Reset is synchronous: cursor 0, no previous key, timeout 5, buffer swept.
module multitap_keypad_text_entry (
   input logic        clock,
   input logic        reset,
   mkte_req_if.sink   req,
   mkte_rsp_if.source rsp,
   mkte_csr_if.sink   csr
);
   import mkte_pkg::*;

   state_type                state_ff, state_in;
   cursor_type               cursor_ff, cursor_in;
   logic [3:0]               last_key_ff, last_key_in;
   logic [1:0]               tap_ff, tap_in;
   logic [7:0]               idle_ff, idle_in;
   logic [7:0]               timeout_ff, timeout_in;
   addr_type                 sweep_ff, sweep_in;
   logic [3:0]               key_ff, key_in;
   logic [3:0]               lk_eff_ff, lk_eff_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     wrote_ff, wrote_in;
   logic [6:0]               index_ff, index_in;
   logic [CHAR_W-1:0]        char_ff, char_in;
   logic [7:0]               cur_now_ff, cur_now_in;

   logic                     out_free;
   logic                     req_take;
   logic                     wr_en, rd_en;
   addr_type                 wr_addr, rd_addr;
   logic [CHAR_W-1:0]        wr_data, rd_data;
   logic [2:0]               tap_inc, tap_size, tap_wrap;
   cursor_type               base_cur, next_cur;
   logic [CHAR_W-1:0]        key_char;

   mkte_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(BUF_DEPTH)
   ) u_text_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign req_take  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.wrote       = wrote_ff;
   assign rsp.write_index = index_ff;
   assign rsp.write_char  = char_ff;
   assign rsp.cursor_now  = cur_now_ff;

   assign tap_inc  = {1'b0, tap_ff} + 3'd1;
   assign tap_size = group_size(key_ff);
   assign tap_wrap = (tap_inc >= tap_size) ? tap_inc - tap_size : tap_inc;

   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      last_key_in  = last_key_ff;
      tap_in       = tap_ff;
      idle_in      = idle_ff;
      timeout_in   = (csr.valid && csr.ready) ? csr.data : timeout_ff;
      sweep_in     = sweep_ff;
      key_in       = key_ff;
      lk_eff_in    = lk_eff_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      wrote_in     = wrote_ff;
      index_in     = index_ff;
      char_in      = char_ff;
      cur_now_in   = cur_now_ff;
      wr_en        = 1'b0;
      wr_addr      = sweep_ff;
      wr_data      = CHAR_SPACE;
      rd_en        = 1'b0;
      rd_addr      = cur_slot(cursor_ff);
      base_cur     = cursor_ff;
      next_cur     = cursor_ff;
      key_char     = CHAR_SPACE;

      unique case (state_ff)
         ST_SWEEP: begin
            wr_en    = 1'b1;
            sweep_in = addr_type'(sweep_ff + addr_type'(1));
            if (sweep_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               wrote_in   = 1'b0;
               index_in   = '0;
               char_in    = CHAR_SPACE;
               cur_now_in = 8'(cursor_ff);
               priority if (req.operation == OP_TICK) begin
                  rsp_valid_in = 1'b1;
                  if (idle_ff != IDLE_MAX) begin
                     idle_in = idle_ff + 8'd1;
                  end
               end else if (req.operation == OP_CLEAR) begin
                  rsp_valid_in = 1'b1;
                  cursor_in    = '0;
                  cur_now_in   = '0;
                  sweep_in     = '0;
                  state_in     = ST_SWEEP;
               end else if (req.operation == OP_KEY && req.key <= KEY_DELETE) begin
                  key_in    = req.key;
                  lk_eff_in = (idle_ff > timeout_ff) ? KEY_NONE : last_key_ff;
                  idle_in   = '0;
                  rd_en     = 1'b1;
                  state_in  = ST_KEY;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_KEY: begin
            if (out_free) begin
               priority if (key_ff == KEY_SPACE) begin
                  base_cur = cur_advance(cursor_ff);
                  next_cur = base_cur;
               end else if (key_ff == KEY_DELETE) begin
                  next_cur = (cursor_ff <= cursor_type'(0)) ? CUR_NEG
                           : cursor_type'(cursor_ff - cursor_type'(1));
               end else if (key_ff == lk_eff_ff) begin
                  tap_in   = tap_wrap[1:0];
                  key_char = CHAR_A + CHAR_W'(group_start(key_ff)) + CHAR_W'(tap_wrap);
               end else begin
                  tap_in   = '0;
                  base_cur = (rd_data != CHAR_SPACE) ? cur_advance(cursor_ff) : cursor_ff;
                  next_cur = base_cur;
                  key_char = CHAR_A + CHAR_W'(group_start(key_ff));
               end
               wr_en        = 1'b1;
               wr_addr      = cur_slot(base_cur);
               wr_data      = key_char;
               cursor_in    = next_cur;
               last_key_in  = key_ff;
               rsp_valid_in = 1'b1;
               wrote_in     = 1'b1;
               index_in     = 7'(cur_slot(base_cur));
               char_in      = key_char;
               cur_now_in   = 8'(next_cur);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            sweep_in = '0;
            state_in = ST_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         cursor_ff    <= '0;
         last_key_ff  <= KEY_NONE;
         tap_ff       <= '0;
         idle_ff      <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         last_key_ff  <= last_key_in;
         tap_ff       <= tap_in;
         idle_ff      <= idle_in;
         timeout_ff   <= timeout_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      lk_eff_ff  <= lk_eff_in;
      wrote_ff   <= wrote_in;
      index_ff   <= index_in;
      char_ff    <= char_in;
      cur_now_ff <= cur_now_in;
   end

`include "multitap_keypad_text_entry_assert.svh"

   `MKTE_ASSERT_SAME(a_cursor_range, clock, reset, 1'b1, cursor_ff >= CUR_NEG, "cursor below -1")
   `MKTE_ASSERT_SAME(a_tap_in_group, clock, reset,
      last_key_ff >= 4'd1 && last_key_ff <= 4'd8, {1'b0, tap_ff} < group_size(last_key_ff),
      "tap count outside letter group")
   `MKTE_ASSERT_NEXT(a_clear_sweeps, clock, reset,
      req_take && req.operation == OP_CLEAR, state_ff == ST_SWEEP && cursor_ff == '0,
      "clear did not start a sweep")
   `MKTE_ASSERT_NEXT(a_key_writes, clock, reset,
      state_ff == ST_KEY && out_free, rsp.valid && rsp.wrote && state_ff == ST_IDLE,
      "key press did not produce a write")

endmodule
